// ===== rtl/core/rsha_pkg.sv =====
// Package for the read statistics histogram accumulator.
// Holds the histogram sizes, field widths, the action codes and the structs shared by the core.
// No dependencies.
package rsha_pkg;

  localparam int LEN_BINS    = 65536;
  localparam int LEN_BIN_W   = $clog2(LEN_BINS);
  localparam int LEN_ADDR_W  = LEN_BIN_W + 1;
  localparam int LEN_DEPTH   = 2 ** LEN_ADDR_W;

  localparam int QUAL_BINS   = 64;
  localparam int QUAL_BIN_W  = $clog2(QUAL_BINS);
  localparam int QUAL_ADDR_W = QUAL_BIN_W + 1;
  localparam int QUAL_DEPTH  = 2 ** QUAL_ADDR_W;

  localparam int CNT_W   = 40;
  localparam int BASE_W  = 56;
  localparam int LEN_W   = 32;
  localparam int QIN_W   = 8;
  localparam int QS_W    = 6;
  localparam int IDX_W   = 16;
  localparam int BIN_W   = 32;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 176;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef enum logic [1:0] {
    ACT_RECORD   = 2'd0,
    ACT_LEN_BIN  = 2'd1,
    ACT_QUAL_BIN = 2'd2
  } action_t;

  typedef struct packed {
    logic                  vld;
    action_t               action;
    logic                  bank;
    logic [LEN_BIN_W-1:0]  lbin;
    logic [QUAL_BIN_W-1:0] qbin;
    logic                  in_range;
  } hist_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  read_count;
    logic [BASE_W-1:0] base_total;
    logic [LEN_W-1:0]  longest;
    logic [QS_W-1:0]   min_q;
    logic [QS_W-1:0]   max_q;
    logic              seen;
  } bank_stats_t;

  typedef struct packed {
    bank_stats_t      stats;
    logic [BIN_W-1:0] bin_count;
  } result_t;

endpackage

// ===== rtl/core/read_stats_histogram_accumulator.sv =====
// Top level of the read statistics histogram accumulator.
// Per-bank totals in registers, histogram store in rsha_hist, four-entry result queue.
// Depends on rsha_pkg and rsha_hist.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata 56b, tuser 3b
//   out_    | out | out_tvalid/tready  | tdata 176b
//
// One transaction per cycle while in_tready is high; results pass s1 into the result queue.
// Histogram bins: read-modify-write on a registered-read memory, forwarded for adjacent hits.
// After reset a sweep clears both bin memories; in_tready stays low meanwhile.
// Output stalls are absorbed by the queue; in_tready drops once four results are pending.
module read_stats_histogram_accumulator
  import rsha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] read_length, [39:32] quality, [55:40] bin_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] action, [2] passed
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [39:0] read_count, [95:40] base_total, [127:96] longest_length,
  // [133:128] min_quality, [139:134] max_quality, [140] min_valid,
  // [172:141] bin_count, [175:173] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  action_t           in_action;
  logic              in_bank;
  logic [LEN_W-1:0]  in_len;
  logic [QIN_W-1:0]  in_qual;
  logic [IDX_W-1:0]  in_idx;
  logic              in_fire;
  logic              rec;

  bank_stats_t       bank_r [2];
  bank_stats_t       cur;
  bank_stats_t       upd;
  bank_stats_t       snap;
  logic [QS_W-1:0]   qsat;
  logic [BASE_W:0]   base_sum;

  hist_req_t         req;
  logic              hist_rdy;
  logic [BIN_W-1:0]  hist_bin;

  logic              s1_vld_r;
  bank_stats_t       s1_stats_r;

  result_t               q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r;
  logic [OQ_PTR_W-1:0]   rd_ptr_r;
  logic [OQ_CNT_W-1:0]   q_cnt_r;
  logic [OQ_CNT_W-1:0]   occ;
  logic                  pop;
  result_t               head;

  assign in_action = action_t'(in_tuser[1:0]);
  assign in_bank   = in_tuser[2];
  assign in_len    = in_tdata[31:0];
  assign in_qual   = in_tdata[39:32];
  assign in_idx    = in_tdata[55:40];
  assign in_fire   = in_tvalid & in_tready;
  assign rec       = (in_action == ACT_RECORD);

  assign occ       = q_cnt_r + {{(OQ_CNT_W-1){1'b0}}, s1_vld_r};
  assign in_tready = hist_rdy && (occ < OQ_CNT_W'(OQ_DEPTH));

  // bank totals after this transaction
  always_comb begin
    cur  = bank_r[in_bank];
    qsat = (in_qual > QIN_W'(QUAL_BINS - 1)) ? QS_W'(QUAL_BINS - 1) : QS_W'(in_qual);
    base_sum = {1'b0, cur.base_total} + (BASE_W + 1)'(in_len);
    upd.read_count = (&cur.read_count) ? cur.read_count : cur.read_count + 1'b1;
    upd.base_total = base_sum[BASE_W] ? {BASE_W{1'b1}} : base_sum[BASE_W-1:0];
    upd.longest    = (cur.longest < in_len) ? in_len : cur.longest;
    upd.min_q      = (!cur.seen || cur.min_q > qsat) ? qsat : cur.min_q;
    upd.max_q      = (cur.max_q < qsat) ? qsat : cur.max_q;
    upd.seen       = 1'b1;
    snap = rec ? upd : cur;
  end

  always_comb begin
    req.vld    = in_fire;
    req.action = in_action;
    req.bank   = in_bank;
    if (rec) begin
      req.lbin     = (in_len < LEN_W'(LEN_BINS)) ? LEN_BIN_W'(in_len) :
                     LEN_BIN_W'(LEN_BINS - 1);
      req.qbin     = QUAL_BIN_W'(qsat);
      req.in_range = 1'b1;
    end else begin
      req.lbin     = LEN_BIN_W'(in_idx);
      req.qbin     = QUAL_BIN_W'(in_idx);
      req.in_range = (in_action == ACT_LEN_BIN) ?
                     (LEN_W'(in_idx) < LEN_W'(LEN_BINS)) :
                     (LEN_W'(in_idx) < LEN_W'(QUAL_BINS));
    end
  end

  rsha_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ready     (hist_rdy),
    .bin_count (hist_bin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        bank_r[i] <= '0;
      end
      s1_vld_r <= 1'b0;
    end else begin
      if (in_fire && rec) bank_r[in_bank] <= upd;
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_stats_r <= snap;
  end

  assign pop        = out_tvalid & out_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign out_tdata  = {3'b000, head.bin_count, head.stats.seen, head.stats.max_q,
                       head.stats.min_q, head.stats.longest, head.stats.base_total,
                       head.stats.read_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (s1_vld_r) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({s1_vld_r, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 1'b1;
        2'b01:   q_cnt_r <= q_cnt_r - 1'b1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      q_r[wr_ptr_r].stats     <= s1_stats_r;
      q_r[wr_ptr_r].bin_count <= hist_bin;
    end
  end

endmodule

// ===== rtl/core/rsha_hist.sv =====
// Histogram store: length and quality bin memories with read-modify-write and forwarding.
// Runs a clearing sweep over both memories after reset.
// Depends on rsha_pkg.
module rsha_hist
  import rsha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hist_req_t        req,
  output logic             ready,
  output logic [BIN_W-1:0] bin_count
);

  logic [BIN_W-1:0] len_mem  [LEN_DEPTH];
  logic [BIN_W-1:0] qual_mem [QUAL_DEPTH];

  logic [LEN_ADDR_W-1:0]  len_raddr;
  logic [QUAL_ADDR_W-1:0] qual_raddr;
  logic [BIN_W-1:0]       len_rd_r;
  logic [BIN_W-1:0]       qual_rd_r;

  logic                   clr_busy_r;
  logic [LEN_ADDR_W-1:0]  clr_idx_r;

  hist_req_t              s1_r;
  logic [LEN_ADDR_W-1:0]  s1_len_addr;
  logic [QUAL_ADDR_W-1:0] s1_qual_addr;

  logic                   fwd_len_vld_r;
  logic [LEN_ADDR_W-1:0]  fwd_len_addr_r;
  logic [BIN_W-1:0]       fwd_len_data_r;
  logic                   fwd_qual_vld_r;
  logic [QUAL_ADDR_W-1:0] fwd_qual_addr_r;
  logic [BIN_W-1:0]       fwd_qual_data_r;

  logic [BIN_W-1:0]       len_old;
  logic [BIN_W-1:0]       qual_old;
  logic                   rec1;
  logic                   len_we;
  logic [LEN_ADDR_W-1:0]  len_waddr;
  logic [BIN_W-1:0]       len_wdata;
  logic                   qual_we;
  logic [QUAL_ADDR_W-1:0] qual_waddr;
  logic [BIN_W-1:0]       qual_wdata;

  assign len_raddr    = {req.bank, req.lbin};
  assign qual_raddr   = {req.bank, req.qbin};
  assign s1_len_addr  = {s1_r.bank, s1_r.lbin};
  assign s1_qual_addr = {s1_r.bank, s1_r.qbin};
  assign ready        = ~clr_busy_r;

  // write in the previous cycle is not yet visible in the registered read
  assign len_old  = (fwd_len_vld_r && fwd_len_addr_r == s1_len_addr) ?
                    fwd_len_data_r : len_rd_r;
  assign qual_old = (fwd_qual_vld_r && fwd_qual_addr_r == s1_qual_addr) ?
                    fwd_qual_data_r : qual_rd_r;

  assign rec1 = s1_r.vld && (s1_r.action == ACT_RECORD);

  always_comb begin
    len_we     = clr_busy_r | rec1;
    qual_we    = clr_busy_r | rec1;
    len_waddr  = s1_len_addr;
    qual_waddr = s1_qual_addr;
    len_wdata  = (&len_old) ? len_old : len_old + 1'b1;
    qual_wdata = (&qual_old) ? qual_old : qual_old + 1'b1;
    if (clr_busy_r) begin
      len_waddr  = clr_idx_r;
      qual_waddr = clr_idx_r[QUAL_ADDR_W-1:0];
      len_wdata  = '0;
      qual_wdata = '0;
    end
  end

  always_comb begin
    bin_count = '0;
    case (s1_r.action)
      ACT_LEN_BIN: begin
        if (s1_r.in_range) bin_count = len_old;
      end
      ACT_QUAL_BIN: begin
        if (s1_r.in_range) bin_count = qual_old;
      end
      default: bin_count = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    len_rd_r <= len_mem[len_raddr];
    if (len_we) len_mem[len_waddr] <= len_wdata;
  end

  always_ff @(posedge clk) begin
    qual_rd_r <= qual_mem[qual_raddr];
    if (qual_we) qual_mem[qual_waddr] <= qual_wdata;
  end

  always_ff @(posedge clk) begin
    s1_r.action     <= req.action;
    s1_r.bank       <= req.bank;
    s1_r.lbin       <= req.lbin;
    s1_r.qbin       <= req.qbin;
    s1_r.in_range   <= req.in_range;
    fwd_len_addr_r  <= len_waddr;
    fwd_len_data_r  <= len_wdata;
    fwd_qual_addr_r <= qual_waddr;
    fwd_qual_data_r <= qual_wdata;
    if (!rst_n) begin
      clr_busy_r     <= 1'b1;
      clr_idx_r      <= '0;
      s1_r.vld       <= 1'b0;
      fwd_len_vld_r  <= 1'b0;
      fwd_qual_vld_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (&clr_idx_r) clr_busy_r <= 1'b0;
      end
      s1_r.vld       <= req.vld;
      fwd_len_vld_r  <= len_we;
      fwd_qual_vld_r <= qual_we;
    end
  end

endmodule

// ===== rtl/core/rsha_checker.sv =====
// Port-level checks for the read statistics histogram accumulator.
// Bound to the top level; depends on rsha_pkg.
// Sees the ports only.
module rsha_checker
  import rsha_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // clearing sweep follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during clearing sweep");

  // a bank with no record has empty totals
  a_empty_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[140] |->
      out_tdata[127:0] == '0 && out_tdata[139:128] == '0)
    else $error("totals non-zero in empty bank");

  // a bank with records has a count and ordered qualities
  a_seen_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[140] |->
      out_tdata[39:0] != '0 && out_tdata[133:128] <= out_tdata[139:134])
    else $error("inconsistent totals in populated bank");

endmodule

bind read_stats_histogram_accumulator rsha_checker u_rsha_checker (.*);

// ===== test/read_stats_histogram_accumulator_tb.sv =====
// Self-checking testbench for read_stats_histogram_accumulator.
// Predicts the per-bank totals and histogram bins, checks every out_ transaction in order.
// Depends on rsha_pkg and the RTL of the block.
module read_stats_histogram_accumulator_tb;
  import rsha_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_SLOTS = 64;

  typedef struct {
    logic [1:0]       action;
    logic             passed;
    logic [LEN_W-1:0] read_length;
    logic [QIN_W-1:0] quality;
    logic [IDX_W-1:0] bin_index;
  } read_item_t;

  typedef struct {
    logic [CNT_W-1:0]  read_count;
    logic [BASE_W-1:0] base_total;
    logic [LEN_W-1:0]  longest;
    logic [QS_W-1:0]   min_q;
    logic [QS_W-1:0]   max_q;
    logic              seen;
    logic [BIN_W-1:0]  bin_count;
  } bank_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tready = 1'b0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;

  // predicted block state
  logic [CNT_W-1:0]  reads_in_bank [2];
  logic [BASE_W-1:0] bases_in_bank [2];
  logic [LEN_W-1:0]  longest_in_bank [2];
  logic [QS_W-1:0]   lowest_q [2];
  logic [QS_W-1:0]   highest_q [2];
  logic              any_read [2];
  logic [BIN_W-1:0]  length_tally [LEN_DEPTH];
  logic [BIN_W-1:0]  quality_tally [QUAL_DEPTH];

  // expected results in order, as a ring
  bank_report_t expected_reports [REPORT_SLOTS];
  int reports_in = 0;
  int reports_out = 0;

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int n_records = 0;
  int n_len_queries = 0;
  int n_qual_queries = 0;
  int n_unused = 0;
  int n_checked = 0;

  read_stats_histogram_accumulator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_req;
    end
  end

  always @(posedge clk) begin
    out_tready <= (hold_left == 0) && (hold_done == hold_req) &&
                  ($urandom_range(99) >= stall_pct);
  end

  function automatic bank_report_t tally_read(read_item_t it);
    bank_report_t rep;
    logic [QS_W-1:0]   q;
    logic [LEN_BIN_W-1:0] lbin;
    logic [BASE_W:0]   sum;
    int b;
    b = int'(it.passed);
    rep.bin_count = '0;
    if (it.action == ACT_RECORD) begin
      q = (it.quality > QUAL_BINS - 1) ? QS_W'(QUAL_BINS - 1) : it.quality[QS_W-1:0];
      lbin = (it.read_length >= LEN_BINS) ? LEN_BIN_W'(LEN_BINS - 1)
                                          : it.read_length[LEN_BIN_W-1:0];
      if (reads_in_bank[b] != '1) reads_in_bank[b] = reads_in_bank[b] + 1'b1;
      sum = {1'b0, bases_in_bank[b]} + (BASE_W + 1)'(it.read_length);
      bases_in_bank[b] = sum[BASE_W] ? '1 : sum[BASE_W-1:0];
      if (longest_in_bank[b] < it.read_length) longest_in_bank[b] = it.read_length;
      if (length_tally[{it.passed, lbin}] != '1)
        length_tally[{it.passed, lbin}] = length_tally[{it.passed, lbin}] + 1'b1;
      if (quality_tally[{it.passed, q}] != '1)
        quality_tally[{it.passed, q}] = quality_tally[{it.passed, q}] + 1'b1;
      if (!any_read[b] || lowest_q[b] > q) begin
        lowest_q[b] = q;
        any_read[b] = 1'b1;
      end
      if (highest_q[b] < q) highest_q[b] = q;
    end else if (it.action == ACT_LEN_BIN) begin
      if (it.bin_index < LEN_BINS)
        rep.bin_count = length_tally[{it.passed, it.bin_index[LEN_BIN_W-1:0]}];
    end else if (it.action == ACT_QUAL_BIN) begin
      if (it.bin_index < QUAL_BINS)
        rep.bin_count = quality_tally[{it.passed, it.bin_index[QUAL_BIN_W-1:0]}];
    end
    rep.read_count = reads_in_bank[b];
    rep.base_total = bases_in_bank[b];
    rep.longest    = longest_in_bank[b];
    rep.min_q      = lowest_q[b];
    rep.max_q      = highest_q[b];
    rep.seen       = any_read[b];
    return rep;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bank_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_in == reports_out) begin
        errors++;
        $display("%0t unexpected result expected none actual %0h", $time, out_tdata);
      end else begin
        want = expected_reports[reports_out % REPORT_SLOTS];
        reports_out++;
        n_checked++;
        check_field("read_count", want.read_count, out_tdata[39:0]);
        check_field("base_total", want.base_total, out_tdata[95:40]);
        check_field("longest_length", want.longest, out_tdata[127:96]);
        check_field("min_quality", want.min_q, out_tdata[133:128]);
        check_field("max_quality", want.max_q, out_tdata[139:134]);
        check_field("min_valid", want.seen, out_tdata[140]);
        check_field("bin_count", want.bin_count, out_tdata[172:141]);
      end
    end
  end

  function automatic read_item_t mk_item(logic [1:0] action, logic passed,
                                         logic [LEN_W-1:0] len, logic [QIN_W-1:0] q,
                                         logic [IDX_W-1:0] idx);
    read_item_t it;
    it.action = action;
    it.passed = passed;
    it.read_length = len;
    it.quality = q;
    it.bin_index = idx;
    return it;
  endfunction

  task automatic send_item(read_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.bin_index, it.quality, it.read_length};
    in_tuser  <= {it.passed, it.action};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_reports[reports_in % REPORT_SLOTS] = tally_read(it);
    reports_in++;
    case (it.action)
      ACT_RECORD:   n_records++;
      ACT_LEN_BIN:  n_len_queries++;
      ACT_QUAL_BIN: n_qual_queries++;
      default:      n_unused++;
    endcase
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (reports_in != reports_out) @(posedge clk);
  endtask

  function automatic read_item_t random_item();
    read_item_t it;
    int pick;
    int sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    it.passed      = 1'($urandom_range(1));
    it.read_length = $urandom;
    it.quality     = QIN_W'($urandom_range(255));
    it.bin_index   = IDX_W'($urandom);
    if (pick < 60) begin
      it.action = ACT_RECORD;
      if (sel < 40)      it.read_length = $urandom_range(300);
      else if (sel < 60) it.read_length = $urandom_range(LEN_BINS - 1);
      else if (sel < 75) it.read_length = $urandom_range(LEN_BINS + 9, LEN_BINS - 6);
      if ($urandom_range(99) < 70) it.quality = QIN_W'($urandom_range(70));
    end else if (pick < 78) begin
      it.action = ACT_LEN_BIN;
      if (sel < 50)      it.bin_index = IDX_W'($urandom_range(300));
      else if (sel < 65) it.bin_index = IDX_W'(LEN_BINS - 1);
    end else if (pick < 95) begin
      it.action = ACT_QUAL_BIN;
      if (sel < 70)      it.bin_index = IDX_W'($urandom_range(QUAL_BINS - 1));
      else if (sel < 85) it.bin_index = IDX_W'($urandom_range(255, QUAL_BINS));
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  task automatic test_directed;
    idle_pct = 0;
    stall_pct = 0;
    send_item(mk_item(ACT_LEN_BIN, 1'b0, 32'd0, 8'd0, 16'd0));
    send_item(mk_item(ACT_QUAL_BIN, 1'b1, 32'd0, 8'd0, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b0, 32'd0, 8'd0, 16'hFFFF));
    send_item(mk_item(ACT_RECORD, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b1, 32'd65535, 8'd63, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b1, 32'd65536, 8'd64, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b0, 32'd1, 8'd200, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b0, 32'd12345, 8'd5, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b1, 32'd0, 8'd0, 16'd0));
    send_item(mk_item(ACT_LEN_BIN, 1'b1, 32'd0, 8'd0, 16'hFFFF));
    send_item(mk_item(ACT_LEN_BIN, 1'b0, 32'd0, 8'd0, 16'd0));
    send_item(mk_item(ACT_LEN_BIN, 1'b0, 32'd0, 8'd0, 16'd1));
    send_item(mk_item(ACT_QUAL_BIN, 1'b1, 32'd0, 8'd0, 16'd63));
    send_item(mk_item(ACT_QUAL_BIN, 1'b0, 32'd0, 8'd0, 16'd63));
    send_item(mk_item(ACT_QUAL_BIN, 1'b1, 32'd0, 8'd0, 16'd64));
    send_item(mk_item(ACT_QUAL_BIN, 1'b0, 32'd0, 8'd0, 16'hFFFF));
    send_item(mk_item(ACT_LEN_BIN, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'd0));
    send_item(mk_item(ACT_UNUSED, 1'b0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    send_item(mk_item(ACT_UNUSED, 1'b1, 32'd0, 8'd0, 16'd0));
    send_item(mk_item(ACT_RECORD, 1'b0, 32'h8000_0000, 8'h80, 16'h8000));
    send_item(mk_item(ACT_LEN_BIN, 1'b0, 32'd0, 8'd0, 16'hFFFF));
    send_item(mk_item(ACT_QUAL_BIN, 1'b0, 32'd0, 8'd0, 16'd0));
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_item(random_item());
    drain();
  endtask

  // receiver holds off while the sender keeps going; input must stall
  task automatic test_backpressure;
    idle_pct = 0;
    stall_pct = 0;
    hold_req <= hold_req + 1;
    repeat (60) send_item(random_item());
    drain();
  endtask

  initial begin
    for (int b = 0; b < 2; b++) begin
      reads_in_bank[b] = '0;
      bases_in_bank[b] = '0;
      longest_in_bank[b] = '0;
      lowest_q[b] = '0;
      highest_q[b] = '0;
      any_read[b] = 1'b0;
    end
    foreach (length_tally[i]) length_tally[i] = '0;
    foreach (quality_tally[i]) quality_tally[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 58, 0);
    test_random(350, 0, 58);
    test_random(350, 22, 22);
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d records, %0d length and %0d quality bin reads, %0d unused actions,",
             n_records, n_len_queries, n_qual_queries, n_unused);
    $display("%0d results checked across idle, stall and long hold-off phases.", n_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rsha_pkg.sv
rtl/core/rsha_hist.sv
rtl/core/read_stats_histogram_accumulator.sv
rtl/core/rsha_checker.sv
test/read_stats_histogram_accumulator_tb.sv
